### hw/rtl/software_timer_table_defines.svh
// ----------------------------------------------------------------------------
// Software timer table assertion macros
// Shared concurrent assertion forms for the timer table modules.
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_TABLE_DEFINES_SVH
`define SOFTWARE_TIMER_TABLE_DEFINES_SVH

// same-cycle implication
`define STT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer table assertion failed");

// next-cycle implication
`define STT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer table assertion failed");

`endif

### hw/rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// Software timer table package
// Sizes, action codes, payload structs and controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

   localparam int NUM_TIMERS = 16;
   localparam int TIME_BITS  = 32;
   localparam int SLOT_BITS  = $clog2(NUM_TIMERS);
   localparam int ID_W       = 5;
   localparam int ACT_W      = 4;
   localparam int DUR_W      = 32;

   localparam logic [ACT_W-1:0] ACT_TICK            = 4'd0;
   localparam logic [ACT_W-1:0] ACT_START_DELAY     = 4'd1;
   localparam logic [ACT_W-1:0] ACT_START_INTERVAL  = 4'd2;
   localparam logic [ACT_W-1:0] ACT_UPDATE_DELAY    = 4'd3;
   localparam logic [ACT_W-1:0] ACT_UPDATE_INTERVAL = 4'd4;
   localparam logic [ACT_W-1:0] ACT_CREATE_DELAY    = 4'd5;
   localparam logic [ACT_W-1:0] ACT_CREATE_INTERVAL = 4'd6;
   localparam logic [ACT_W-1:0] ACT_CANCEL          = 4'd7;
   localparam logic [ACT_W-1:0] ACT_CANCEL_ALL      = 4'd8;
   localparam logic [ACT_W-1:0] ACT_QUERY           = 4'd9;

   typedef logic [TIME_BITS-1:0] time_ms_type;
   typedef logic [SLOT_BITS-1:0] slot_type;
   typedef logic [ID_W-1:0]      id_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic [ID_W-1:0]  timer_id;
      logic [DUR_W-1:0] duration_ms;
   } req_payload_type;

   typedef struct packed {
      logic            kind;
      logic [ID_W-1:0] result_id;
      logic            ok;
      logic            last;
   } rsp_payload_type;

   typedef struct packed {
      logic     load_req;
      logic     adv_now;
      logic     rd_en;
      slot_type rd_addr;
      logic     exec;
      logic     scan_step;
      logic     drain;
   } dp_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic is_cmd;
      logic out_free;
      logic expired;
      logic pend_valid;
   } dp_status_type;

endpackage

`default_nettype wire

### hw/rtl/stt_ctrl.sv
// ----------------------------------------------------------------------------
// Software timer table controller
// Sequences request decode, command execution and the descending slot scan.
// ----------------------------------------------------------------------------
`default_nettype none
`include "software_timer_table_defines.svh"

module stt_ctrl import stt_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_EXEC,
      S_SCAN,
      S_DRAIN
   } state_type;

   localparam slot_type LAST_SLOT = SLOT_BITS'(NUM_TIMERS - 1);

   state_type state_ff, state_in;
   slot_type  idx_ff, idx_in;
   logic      req_stall_ff, req_stall_in;
   logic      scan_go;

   assign scan_go = !status.expired || !status.pend_valid || status.out_free;

   always_comb begin
      cmd          = '0;
      cmd.rd_addr  = idx_ff;
      state_in     = state_ff;
      idx_in       = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall_ff) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.is_tick) begin
               cmd.adv_now = 1'b1;
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = LAST_SLOT;
               idx_in      = LAST_SLOT;
               state_in    = S_SCAN;
            end else if (status.is_cmd) begin
               state_in = S_EXEC;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EXEC: begin
            if (status.out_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (scan_go) begin
               cmd.scan_step = 1'b1;
               if (idx_ff == '0) begin
                  state_in = S_DRAIN;
               end else begin
                  idx_in      = idx_ff - 1'b1;
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = idx_ff - 1'b1;
               end
            end
         end
         S_DRAIN: begin
            if (!status.pend_valid || status.out_free) begin
               cmd.drain = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      req_stall_in = (state_in != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         req_stall_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         req_stall_ff <= req_stall_in;
      end
   end

   assign req_stall = req_stall_ff;

   `STT_ASSERT_NXT(a_scan_hold, clock, reset, state_ff == S_SCAN && !scan_go, state_ff == S_SCAN && $stable(idx_ff))
   `STT_ASSERT_IMP(a_idle_no_pend, clock, reset, state_ff == S_IDLE, !status.pend_valid)

endmodule

`default_nettype wire

### hw/rtl/stt_datapath.sv
// ----------------------------------------------------------------------------
// Software timer table datapath
// Slot flags, deadline and period memories, time counter, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "software_timer_table_defines.svh"

module stt_datapath import stt_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire req_payload_type req_data,
   output rsp_payload_type      rsp_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   input  wire dp_cmd_type      cmd,
   output dp_status_type        status
);

   time_ms_type dl_mem [NUM_TIMERS];
   time_ms_type pd_mem [NUM_TIMERS];

   req_payload_type        req_ff;
   time_ms_type            dl_rd_ff, pd_rd_ff;
   slot_type               rd_slot_ff;
   time_ms_type            now_ff, now_in;
   logic [NUM_TIMERS-1:0]  valid_ff, valid_in;
   logic [NUM_TIMERS-1:0]  periodic_ff, periodic_in;
   logic                   pend_valid_ff, pend_valid_in;
   id_type                 pend_id_ff, pend_id_in;
   rsp_payload_type        rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_load;

   logic        dl_we, pd_we;
   slot_type    dl_waddr, pd_waddr;
   time_ms_type dl_wdata, pd_wdata;

   time_ms_type dur;
   slot_type    hit_slot, free_slot;
   id_type      hit_id, free_id, ack_id;
   logic        id_in_range, hit, full, ack_ok;
   logic        do_start, start_per, do_upd_dl, do_upd_pd;
   logic        expired;

   assign dur         = TIME_BITS'(req_ff.duration_ms);
   assign id_in_range = (req_ff.timer_id != '0) && (req_ff.timer_id <= ID_W'(NUM_TIMERS));
   assign hit_slot    = SLOT_BITS'(req_ff.timer_id - 1'b1);
   assign hit         = id_in_range && valid_ff[hit_slot];
   assign hit_id      = ID_W'(hit_slot) + ID_W'(1);
   assign free_id     = ID_W'(free_slot) + ID_W'(1);

   always_comb begin
      free_slot = '0;
      full      = 1'b1;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = SLOT_BITS'(i);
            full      = 1'b0;
         end
      end
   end

   assign expired = valid_ff[rd_slot_ff] && !(dl_rd_ff > now_ff);

   always_comb begin
      now_in        = cmd.adv_now ? now_ff + 1'b1 : now_ff;
      valid_in      = valid_ff;
      periodic_in   = periodic_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      rsp_load      = 1'b0;
      rsp_in        = rsp_ff;
      dl_we         = 1'b0;
      dl_waddr      = hit_slot;
      dl_wdata      = now_ff + dur;
      pd_we         = 1'b0;
      pd_waddr      = hit_slot;
      pd_wdata      = dur;
      do_start      = 1'b0;
      start_per     = 1'b0;
      do_upd_dl     = 1'b0;
      do_upd_pd     = 1'b0;
      ack_id        = '0;
      ack_ok        = 1'b0;

      if (cmd.exec) begin
         case (req_ff.action) inside
            ACT_START_DELAY, ACT_START_INTERVAL: begin
               do_start  = 1'b1;
               start_per = (req_ff.action == ACT_START_INTERVAL);
            end
            ACT_UPDATE_DELAY, ACT_UPDATE_INTERVAL, ACT_CREATE_DELAY, ACT_CREATE_INTERVAL: begin
               if (hit) begin
                  ack_id = hit_id;
                  if (req_ff.action == ACT_UPDATE_DELAY || req_ff.action == ACT_CREATE_DELAY) begin
                     do_upd_dl = 1'b1;
                  end else begin
                     do_upd_pd = 1'b1;
                  end
               end else if (req_ff.action == ACT_CREATE_DELAY ||
                            req_ff.action == ACT_CREATE_INTERVAL) begin
                  do_start  = 1'b1;
                  start_per = (req_ff.action == ACT_CREATE_INTERVAL);
               end
            end
            ACT_CANCEL: begin
               if (hit) begin
                  valid_in[hit_slot]    = 1'b0;
                  periodic_in[hit_slot] = 1'b0;
                  ack_id                = hit_id;
               end
            end
            ACT_CANCEL_ALL: begin
               valid_in    = '0;
               periodic_in = '0;
            end
            ACT_QUERY: begin
               if (hit) begin
                  ack_id = hit_id;
               end
            end
            default: begin
            end
         endcase

         if (do_start && !full) begin
            valid_in[free_slot]    = 1'b1;
            periodic_in[free_slot] = start_per;
            dl_we    = 1'b1;
            dl_waddr = free_slot;
            pd_we    = 1'b1;
            pd_waddr = free_slot;
            ack_id   = free_id;
         end
         if (do_upd_dl) begin
            dl_we = 1'b1;
         end
         if (do_upd_pd) begin
            pd_we                 = 1'b1;
            periodic_in[hit_slot] = 1'b1;
         end

         ack_ok = (req_ff.action == ACT_CANCEL_ALL) || (ack_id != '0);
         rsp_load = 1'b1;
         rsp_in   = '{kind: 1'b0, result_id: ack_id, ok: ack_ok, last: 1'b1};
      end

      if (cmd.scan_step && expired) begin
         if (pend_valid_ff) begin
            rsp_load = 1'b1;
            rsp_in   = '{kind: 1'b1, result_id: pend_id_ff, ok: 1'b1, last: 1'b0};
         end
         pend_valid_in = 1'b1;
         pend_id_in    = ID_W'(rd_slot_ff) + ID_W'(1);
         if (periodic_ff[rd_slot_ff]) begin
            dl_we    = 1'b1;
            dl_waddr = rd_slot_ff;
            dl_wdata = now_ff + pd_rd_ff;
         end else begin
            valid_in[rd_slot_ff] = 1'b0;
         end
      end

      if (cmd.drain && pend_valid_ff) begin
         rsp_load      = 1'b1;
         rsp_in        = '{kind: 1'b1, result_id: pend_id_ff, ok: 1'b1, last: 1'b1};
         pend_valid_in = 1'b0;
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff        <= '0;
         valid_ff      <= '0;
         periodic_ff   <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         now_ff        <= now_in;
         valid_ff      <= valid_in;
         periodic_ff   <= periodic_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      pend_id_ff <= pend_id_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (dl_we) begin
         dl_mem[dl_waddr] <= dl_wdata;
      end
      if (pd_we) begin
         pd_mem[pd_waddr] <= pd_wdata;
      end
      if (cmd.rd_en) begin
         dl_rd_ff   <= dl_mem[cmd.rd_addr];
         pd_rd_ff   <= pd_mem[cmd.rd_addr];
         rd_slot_ff <= cmd.rd_addr;
      end
   end

   assign status.is_tick    = (req_ff.action == ACT_TICK);
   assign status.is_cmd     = (req_ff.action >= ACT_START_DELAY) && (req_ff.action <= ACT_QUERY);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign status.expired    = expired;
   assign status.pend_valid = pend_valid_ff;

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   `STT_ASSERT_NXT(a_drain_last, clock, reset, cmd.drain && pend_valid_ff, rsp_valid_ff && rsp_ff.last && rsp_ff.kind)
   `STT_ASSERT_NXT(a_cancel_all, clock, reset, cmd.exec && req_ff.action == ACT_CANCEL_ALL, valid_ff == '0)

endmodule

`default_nettype wire

### hw/rtl/software_timer_table.sv
// ----------------------------------------------------------------------------
// Software timer table
// Table of one-shot and periodic timers with an internal millisecond count.
//
// Request channel (req_valid, req_stall, req_data) carries one action per
// transfer: a tick or a timer command. Result channel (rsp_valid, rsp_stall,
// rsp_data) returns one acknowledgement per command, or one fire result per
// expired timer on a tick, highest slot first, with last set on the final one.
// A command passes through decode and execute states and its acknowledgement
// is registered in the output register; the next request can transfer in the
// cycle in which that acknowledgement is presented. A tick advances the count,
// then scans one slot per cycle, unless a fire waits on a held result, through
// the single read port of the deadline and period memories. Undefined action
// codes give nothing. A stalled result holds in the output register; a scan
// waits on a second fire while one is already pending and the output register
// is held. Reset frees every slot and clears the count, with no clearing pass;
// req_stall stays high during reset.
// ----------------------------------------------------------------------------
`default_nettype none

module software_timer_table import stt_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   stt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   stt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Software timer table testbench
// Runs a table of directed actions, a back-pressure phase that fills every
// slot, then random runs of starts, ticks and commands. Each result transfer
// is compared field by field with the directed table's result or else with the
// output of an in-bench model of the timer slots and the millisecond count.
// ----------------------------------------------------------------------------

module tb import stt_pkg::*; ();

   localparam int CLOCK_HALF    = 5;
   localparam int RESET_CYCLES  = 4;
   localparam int RANDOM_ITEMS  = 100;
   localparam int CALM_ITEMS    = 25;
   localparam int LONG_HOLD     = 200;
   localparam int SETTLE_CYCLES = NUM_TIMERS + 8;
   localparam int REPORT_MAX    = 10;
   localparam int LIMIT_NS      = 5_000_000;

   localparam bit KIND_ACK  = 1'b0;
   localparam bit KIND_FIRE = 1'b1;

   localparam logic [ACT_W-1:0] ACT_UNDEF_LO = 4'd10;
   localparam logic [ACT_W-1:0] ACT_UNDEF_HI = 4'd15;
   localparam id_type           ID_TOP       = '1;
   localparam logic [DUR_W-1:0] DUR_TOP      = '1;

   typedef enum logic [1:0] {
      BY_MODEL,
      NO_RESULT,
      ONE_RESULT
   } check_mode_type;

   typedef struct packed {
      check_mode_type  mode;
      req_payload_type req;
      rsp_payload_type rsp;
   } stim_row_type;

   localparam rsp_payload_type NO_RSP   = '0;
   localparam rsp_payload_type ACK_FAIL = '{KIND_ACK, 5'd0, 1'b0, 1'b1};
   localparam int DIRECTED_N = 24;

   localparam stim_row_type DIRECTED_ROWS [DIRECTED_N] = '{
      '{ONE_RESULT, '{ACT_QUERY,           5'd1,   32'd0},   ACK_FAIL},
      '{ONE_RESULT, '{ACT_CANCEL,          5'd0,   32'd0},   ACK_FAIL},
      '{ONE_RESULT, '{ACT_UPDATE_DELAY,    ID_TOP, DUR_TOP}, ACK_FAIL},
      '{ONE_RESULT, '{ACT_UPDATE_INTERVAL, 5'd16,  32'd0},   ACK_FAIL},
      '{NO_RESULT,  '{ACT_TICK,            ID_TOP, DUR_TOP}, NO_RSP},
      '{ONE_RESULT, '{ACT_START_DELAY,     5'd0,   32'd0},
                    '{KIND_ACK, 5'd1, 1'b1, 1'b1}},
      '{ONE_RESULT, '{ACT_START_INTERVAL,  5'd0,   DUR_TOP},
                    '{KIND_ACK, 5'd2, 1'b1, 1'b1}},
      '{BY_MODEL,   '{ACT_TICK,            5'd0,   32'd0},   NO_RSP},
      '{BY_MODEL,   '{ACT_START_INTERVAL,  5'd0,   32'd3},   NO_RSP},
      '{BY_MODEL,   '{ACT_UPDATE_INTERVAL, 5'd3,   32'd2},   NO_RSP},
      '{BY_MODEL,   '{ACT_UPDATE_DELAY,    5'd2,   32'd5},   NO_RSP},
      '{BY_MODEL,   '{ACT_CREATE_DELAY,    5'd0,   32'd1},   NO_RSP},
      '{BY_MODEL,   '{ACT_CREATE_INTERVAL, 5'd2,   32'd1},   NO_RSP},
      '{BY_MODEL,   '{ACT_CREATE_INTERVAL, 5'd20,  32'd0},   NO_RSP},
      '{BY_MODEL,   '{ACT_QUERY,           5'd2,   32'd0},   NO_RSP},
      '{NO_RESULT,  '{ACT_UNDEF_LO,        5'd1,   32'd1},   NO_RSP},
      '{NO_RESULT,  '{ACT_UNDEF_HI,        ID_TOP, DUR_TOP}, NO_RSP},
      '{BY_MODEL,   '{ACT_TICK,            5'd0,   32'd0},   NO_RSP},
      '{BY_MODEL,   '{ACT_TICK,            ID_TOP, DUR_TOP}, NO_RSP},
      '{BY_MODEL,   '{ACT_CANCEL,          5'd2,   32'd0},   NO_RSP},
      '{BY_MODEL,   '{ACT_QUERY,           5'd2,   32'd0},   NO_RSP},
      '{ONE_RESULT, '{ACT_CANCEL_ALL,      5'd0,   32'd0},
                    '{KIND_ACK, 5'd0, 1'b1, 1'b1}},
      '{BY_MODEL,   '{ACT_TICK,            5'd0,   32'd0},   NO_RSP},
      '{ONE_RESULT, '{ACT_QUERY,           5'd1,   32'd0},   ACK_FAIL}
   };

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_data;

   bit slot_live   [NUM_TIMERS];
   bit slot_repeat [NUM_TIMERS];
   time_ms_type slot_due   [NUM_TIMERS];
   time_ms_type slot_every [NUM_TIMERS];
   time_ms_type ms_count = '0;

   rsp_payload_type pending_rsp_q[$];
   rsp_payload_type want;

   bit hold_long  = 1'b0;
   bit calm       = 1'b0;
   int items_done = 0;
   int fires_seen = 0;
   int acks_seen  = 0;
   int mismatches = 0;

   software_timer_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   function automatic rsp_payload_type make_rsp(bit kind, id_type id, bit ok, bit last);
      rsp_payload_type r;
      r.kind      = kind;
      r.result_id = id;
      r.ok        = ok;
      r.last      = last;
      return r;
   endfunction

   function automatic req_payload_type make_req(logic [ACT_W-1:0] action, id_type id,
                                                logic [DUR_W-1:0] dur);
      req_payload_type r;
      r.action      = action;
      r.timer_id    = id;
      r.duration_ms = dur;
      return r;
   endfunction

   function automatic void queue_expected(rsp_payload_type r);
      pending_rsp_q = {pending_rsp_q, r};
   endfunction

   function automatic int slot_of(id_type id);
      if (id == 0 || id > NUM_TIMERS) begin
         return -1;
      end
      if (!slot_live[id - 1]) begin
         return -1;
      end
      return int'(id) - 1;
   endfunction

   function automatic id_type arm_free_slot(bit periodic, logic [DUR_W-1:0] dur);
      for (int i = 0; i < NUM_TIMERS; i++) begin
         if (!slot_live[i]) begin
            slot_live[i]   = 1'b1;
            slot_repeat[i] = periodic;
            slot_every[i]  = periodic ? time_ms_type'(dur) : '0;
            slot_due[i]    = ms_count + time_ms_type'(dur);
            return id_type'(i + 1);
         end
      end
      return '0;
   endfunction

   // Apply one accepted request to the slot table; queue its results if asked.
   function automatic void table_step(req_payload_type r, bit record);
      rsp_payload_type res[$];
      int s;
      id_type rid;
      rid = '0;
      case (r.action) inside
         ACT_TICK: begin
            ms_count = ms_count + 1'b1;
            for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
               if (slot_live[i] && slot_due[i] <= ms_count) begin
                  res = {res, make_rsp(KIND_FIRE, id_type'(i + 1), 1'b1, 1'b0)};
                  if (slot_repeat[i]) begin
                     slot_due[i] = ms_count + slot_every[i];
                  end else begin
                     slot_live[i] = 1'b0;
                  end
               end
            end
            if (res.size() > 0) begin
               res[res.size() - 1].last = 1'b1;
            end
         end
         ACT_START_DELAY, ACT_START_INTERVAL: begin
            rid = arm_free_slot(r.action == ACT_START_INTERVAL, r.duration_ms);
            res = {res, make_rsp(KIND_ACK, rid, rid != 0, 1'b1)};
         end
         ACT_UPDATE_DELAY, ACT_UPDATE_INTERVAL, ACT_CREATE_DELAY, ACT_CREATE_INTERVAL: begin
            s = slot_of(r.timer_id);
            if (s >= 0) begin
               if (r.action == ACT_UPDATE_DELAY || r.action == ACT_CREATE_DELAY) begin
                  slot_due[s] = ms_count + time_ms_type'(r.duration_ms);
               end else begin
                  slot_repeat[s] = 1'b1;
                  slot_every[s]  = time_ms_type'(r.duration_ms);
               end
               rid = id_type'(s + 1);
            end else if (r.action == ACT_CREATE_DELAY || r.action == ACT_CREATE_INTERVAL) begin
               rid = arm_free_slot(r.action == ACT_CREATE_INTERVAL, r.duration_ms);
            end
            res = {res, make_rsp(KIND_ACK, rid, rid != 0, 1'b1)};
         end
         ACT_CANCEL: begin
            s = slot_of(r.timer_id);
            if (s >= 0) begin
               slot_live[s]   = 1'b0;
               slot_repeat[s] = 1'b0;
               rid            = id_type'(s + 1);
            end
            res = {res, make_rsp(KIND_ACK, rid, s >= 0, 1'b1)};
         end
         ACT_CANCEL_ALL: begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
               slot_live[i]   = 1'b0;
               slot_repeat[i] = 1'b0;
            end
            res = {res, make_rsp(KIND_ACK, '0, 1'b1, 1'b1)};
         end
         ACT_QUERY: begin
            s = slot_of(r.timer_id);
            if (s >= 0) begin
               rid = id_type'(s + 1);
            end
            res = {res, make_rsp(KIND_ACK, rid, s >= 0, 1'b1)};
         end
         default: begin
         end
      endcase
      if (record) begin
         foreach (res[i]) queue_expected(res[i]);
      end
   endfunction

   function automatic void log_mismatch(string what, rsp_payload_type exp_rsp,
                                        rsp_payload_type got);
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
         $display("%0t %s: expected kind %0d id %0d ok %0d last %0d, got kind %0d id %0d ok %0d last %0d",
                  $time, what, exp_rsp.kind, exp_rsp.result_id, exp_rsp.ok, exp_rsp.last,
                  got.kind, got.result_id, got.ok, got.last);
      end
   endfunction

   function automatic logic [DUR_W-1:0] pick_dur();
      case ($urandom_range(0, 7))
         0: return DUR_TOP ^ $urandom();
         1: return DUR_TOP - DUR_W'($urandom_range(0, 40));
         default: return DUR_W'($urandom_range(0, 12));
      endcase
   endfunction

   // Mostly a running timer, otherwise any id the field can carry.
   function automatic id_type pick_id();
      id_type live_ids[$];
      for (int i = 0; i < NUM_TIMERS; i++) begin
         if (slot_live[i]) live_ids = {live_ids, id_type'(i + 1)};
      end
      if (live_ids.size() > 0 && $urandom_range(0, 9) < 6) begin
         return live_ids[$urandom_range(0, live_ids.size() - 1)];
      end
      return id_type'($urandom_range(0, 31));
   endfunction

   task automatic send_item(req_payload_type p, check_mode_type mode, rsp_payload_type typed);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 11);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (req_stall);
      table_step(p, mode == BY_MODEL);
      if (mode == ONE_RESULT) begin
         queue_expected(typed);
      end
      if (p.action <= ACT_QUERY) begin
         items_done++;
      end
   endtask

   task automatic send_cmd(logic [ACT_W-1:0] action, id_type id, logic [DUR_W-1:0] dur);
      send_item(make_req(action, id, dur), BY_MODEL, NO_RSP);
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_rsp_q.size() == 0);
   endtask

   initial begin : stimulus
      int base;
      int n;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int k = 0; k < DIRECTED_N; k++) begin
         send_item(DIRECTED_ROWS[k].req, DIRECTED_ROWS[k].mode, DIRECTED_ROWS[k].rsp);
      end
      pause_until_drained();

      // hold the result side while every slot is filled and fired
      hold_long = 1'b1;
      for (int k = 0; k <= NUM_TIMERS; k++) begin
         send_cmd(ACT_START_INTERVAL, id_type'($urandom_range(0, 31)), '0);
      end
      repeat (3) send_cmd(ACT_TICK, id_type'($urandom_range(0, 31)), $urandom());
      send_cmd(ACT_CANCEL_ALL, '0, '0);
      pause_until_drained();

      base = items_done;
      while (items_done - base < RANDOM_ITEMS) begin
         calm = (items_done - base >= RANDOM_ITEMS - CALM_ITEMS);
         case ($urandom_range(0, 9))
            0, 1: begin
               n = $urandom_range(2, NUM_TIMERS + 1);
               repeat (n) begin
                  send_cmd($urandom_range(0, 1) ? ACT_START_INTERVAL : ACT_START_DELAY,
                           id_type'($urandom_range(0, 31)), pick_dur());
               end
            end
            2, 3, 4: begin
               n = $urandom_range(1, 8);
               repeat (n) send_cmd(ACT_TICK, id_type'($urandom_range(0, 31)), $urandom());
            end
            5, 6, 7: begin
               n = $urandom_range(1, 4);
               repeat (n) begin
                  case ($urandom_range(0, 7))
                     0: send_cmd(ACT_UPDATE_DELAY, pick_id(), pick_dur());
                     1: send_cmd(ACT_UPDATE_INTERVAL, pick_id(), pick_dur());
                     2: send_cmd(ACT_CREATE_DELAY, pick_id(), pick_dur());
                     3: send_cmd(ACT_CREATE_INTERVAL, pick_id(), pick_dur());
                     4, 5: send_cmd(ACT_CANCEL, pick_id(), $urandom());
                     6: send_cmd(ACT_QUERY, pick_id(), $urandom());
                     default: send_cmd(ACT_START_DELAY, pick_id(), pick_dur());
                  endcase
               end
            end
            8: begin
               send_cmd(ACT_CANCEL_ALL, id_type'($urandom_range(0, 31)), $urandom());
            end
            default: begin
               send_cmd(ACT_W'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI)),
                        id_type'($urandom_range(0, 31)), $urandom());
               send_cmd(ACT_W'($urandom_range(ACT_UPDATE_DELAY, ACT_QUERY)),
                        id_type'($urandom_range(0, 31)), pick_dur());
            end
         endcase
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_rsp_q.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_rsp_q.size() != 0) begin
         mismatches += pending_rsp_q.size();
         $display("%0d expected results never arrived", pending_rsp_q.size());
      end
      $display("ran %0d requests up to count %0d ms", items_done, ms_count);
      $display("checked %0d timer fires and %0d command acknowledgements", fires_seen, acks_seen);
      if (mismatches == 0) begin
         $display("software_timer_table: match");
      end else begin
         $display("software_timer_table: mismatch");
      end
      $finish;
   end

   initial begin : receiver
      int burst;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_long) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD - 1) @(negedge clock);
            hold_long = 1'b0;
         end else if (!calm && !reset && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 11);
            rsp_stall <= 1'b1;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp_q.size() == 0) begin
            log_mismatch("unexpected result", NO_RSP, rsp_data);
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_data.kind !== want.kind || rsp_data.result_id !== want.result_id ||
                rsp_data.ok !== want.ok || rsp_data.last !== want.last) begin
               log_mismatch("result mismatch", want, rsp_data);
            end
            if (want.kind == KIND_FIRE) begin
               fires_seen++;
            end else begin
               acks_seen++;
            end
         end
      end
   end

   initial begin : watchdog
      #LIMIT_NS;
      $display("software_timer_table: mismatch");
      $finish;
   end

endmodule

### software_timer_table.f
+incdir+hw/rtl
hw/rtl/stt_pkg.sv
hw/rtl/stt_ctrl.sv
hw/rtl/stt_datapath.sv
hw/rtl/software_timer_table.sv
bench/tb.sv
